### design/msp_pkg.sv
package msp_pkg;

	localparam int MSG_DEPTH_DEF        = 512;
	localparam int MAX_ELEMS_DEF        = 7;
	localparam int QUEUE_DEPTH          = 4;
	localparam int UNIT_W               = 16;
	localparam int CNT_W                = 19;
	localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd100;

	localparam logic [7:0] BYTE_DOT  = 8'h2E;
	localparam logic [7:0] BYTE_DASH = 8'h2D;
	localparam logic [7:0] BYTE_CR   = 8'h0D;
	localparam logic [7:0] BYTE_NUL  = 8'h00;

	typedef enum logic [2:0] {
		CODE_DOT        = 3'd0,
		CODE_DASH       = 3'd1,
		CODE_SPACE      = 3'd2,
		CODE_LETTER_END = 3'd3,
		CODE_MSG_END    = 3'd4
	} code_t;

	typedef struct packed {
		logic  is_tick;
		code_t code;
	} cmd_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] symbol_byte;
	} in_item_t;

	typedef struct packed {
		logic key_on;
		logic playing;
		logic overflow;
	} out_item_t;

endpackage

### design/morse_playback_sequencer_top.sv
// morse playback sequencer
// input channel (in_valid/in_ready/in_item): each beat is either a tick
// (req_type 0) or a message byte (req_type 1). '.' dot, '-' dash, CR letter
// end, NUL message end, anything else a word space. bytes fill a pending
// message; a complete one is loaded at once when idle, else at the end of the
// playing message's closing gap. the loaded message loops.
// output channel (out_valid/out_ready/out_item): one beat per tick carrying
// key_on, playing and the sticky overflow flag; byte beats give no result.
// cfg_we/cfg_wdata sets unit_ticks (ticks per morse unit, 0 acts as 1);
// write it only while the block is quiet.
// throughput: one beat per cycle while the output is not stalled. a tick's
// result passes through the command queue, then the output register, before
// out_valid rises.
// a stalled output holds its register; bytes ahead of the next tick still
// drain, the rest wait in the 4-entry queue, and in_ready drops once it fills.
// reset: idle, no message, unit_ticks 100, overflow clear, queue empty.
// no clearing pass: message memory is used only where it was written.
module morse_playback_sequencer_top #(
	parameter int MSG_DEPTH = msp_pkg::MSG_DEPTH_DEF,
	parameter int MAX_ELEMS = msp_pkg::MAX_ELEMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [msp_pkg::UNIT_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  msp_pkg::in_item_t          in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output msp_pkg::out_item_t         out_item
);
	import msp_pkg::*;

	logic push;
	logic push_ready;
	cmd_t push_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	msp_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push       (push),
		.push_ready (push_ready),
		.cmd        (push_cmd)
	);

	msp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	msp_back #(
		.MSG_DEPTH (MSG_DEPTH),
		.MAX_ELEMS (MAX_ELEMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

### design/msp_front.sv
module msp_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  msp_pkg::in_item_t in_item,
	output logic              push,
	input  logic              push_ready,
	output msp_pkg::cmd_t     cmd
);
	import msp_pkg::*;

	assign in_ready = push_ready;
	assign push     = in_valid && push_ready;

	always_comb begin
		cmd.is_tick = !in_item.req_type;
		case (in_item.symbol_byte)
			BYTE_NUL:  cmd.code = CODE_MSG_END;
			BYTE_CR:   cmd.code = CODE_LETTER_END;
			BYTE_DOT:  cmd.code = CODE_DOT;
			BYTE_DASH: cmd.code = CODE_DASH;
			default:   cmd.code = CODE_SPACE;
		endcase
	end

endmodule

### design/msp_queue.sv
module msp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          push_ready,
	input  msp_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output msp_pkg::cmd_t pop_cmd
);
	import msp_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### design/msp_back.sv
module msp_back #(
	parameter int MSG_DEPTH = msp_pkg::MSG_DEPTH_DEF,
	parameter int MAX_ELEMS = msp_pkg::MAX_ELEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [msp_pkg::UNIT_W-1:0]  cfg_wdata,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  msp_pkg::cmd_t               cmd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output msp_pkg::out_item_t          out_item
);
	import msp_pkg::*;

	localparam int AW = $clog2(MSG_DEPTH);
	localparam int EW = $clog2(MAX_ELEMS + 1);
	localparam int MEM_ENTRIES = 2 ** (AW + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MSG_DEPTH - 1);
	localparam logic [EW-1:0] ELEM_MAX  = EW'(MAX_ELEMS);

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_ON         = 5'b00010,
		PH_OFF        = 5'b00100,
		PH_LETTER_GAP = 5'b01000,
		PH_MSG_GAP    = 5'b10000
	} phase_t;

	// both messages share one memory, the bank bit picks the playing half
	code_t          mem [MEM_ENTRIES];
	code_t          rd_data_q;
	logic           rd_req_q;
	logic [AW:0]    rd_addr_q;

	logic [UNIT_W-1:0] unit_ticks_q;
	phase_t         phase_q, phase_d;
	logic           key_q, key_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [AW-1:0]  rp_q, rp_d;
	logic [AW-1:0]  wp_q, wp_d;
	logic [EW-1:0]  elems_q, elems_d;
	logic           pend_q, pend_d;
	logic           ovf_q, ovf_d;
	logic           bank_q, bank_d;
	code_t          head_act_q, head_act_d;
	code_t          head_pend_q, head_pend_d;

	logic           out_valid_q;
	out_item_t      out_item_q;
	out_item_t      res;
	logic           slot_free;
	logic           fire;

	logic           wr_en;
	code_t          wr_code;
	logic           rd_req_d;
	logic [AW-1:0]  rd_off_d;

	logic           do_load;
	logic           do_letter;
	logic           do_elem;
	code_t          sl_code;
	logic [CNT_W-1:0] u1, u2, u3, u5, u7, cnt_dec;
	logic [UNIT_W-1:0] u;

	assign u  = (unit_ticks_q == '0) ? UNIT_W'(1) : unit_ticks_q;
	assign u1 = CNT_W'(u);
	assign u2 = CNT_W'({u, 1'b0});
	assign u3 = u1 + u2;
	assign u5 = u1 + CNT_W'({u, 2'b00});
	assign u7 = CNT_W'({u, 3'b000}) - u1;
	assign cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : '0;

	assign slot_free = !out_valid_q || out_ready;
	assign cmd_ready = !cmd.is_tick || slot_free;
	assign fire      = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		phase_d     = phase_q;
		key_d       = key_q;
		cnt_d       = cnt_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		elems_d     = elems_q;
		pend_d      = pend_q;
		ovf_d       = ovf_q;
		bank_d      = bank_q;
		head_act_d  = head_act_q;
		head_pend_d = head_pend_q;
		wr_en       = 1'b0;
		wr_code     = cmd.code;
		rd_req_d    = 1'b0;
		rd_off_d    = rp_q;
		do_load     = 1'b0;
		do_letter   = 1'b0;
		do_elem     = 1'b0;
		sl_code     = head_act_q;
		res         = '0;

		if (fire && !cmd.is_tick) begin
			if (pend_q) begin
				ovf_d = 1'b1;
			end else if (cmd.code == CODE_MSG_END) begin
				wr_en  = 1'b1;
				pend_d = 1'b1;
				if (wp_q == '0)
					head_pend_d = CODE_MSG_END;
				if (phase_q == PH_IDLE) begin
					do_load = 1'b1;
					sl_code = (wp_q == '0) ? CODE_MSG_END : head_pend_q;
				end
			end else if (wp_q == LAST_ADDR) begin
				ovf_d = 1'b1;
			end else if (cmd.code == CODE_LETTER_END) begin
				wr_en   = 1'b1;
				wp_d    = wp_q + 1'b1;
				elems_d = '0;
				if (wp_q == '0)
					head_pend_d = cmd.code;
			end else if (elems_q >= ELEM_MAX) begin
				ovf_d = 1'b1;
			end else begin
				wr_en   = 1'b1;
				wp_d    = wp_q + 1'b1;
				elems_d = elems_q + 1'b1;
				if (wp_q == '0)
					head_pend_d = cmd.code;
			end
		end else if (fire) begin
			res.overflow = ovf_q;
			if (phase_q == PH_IDLE) begin
				key_d = 1'b0;
			end else begin
				res.key_on  = key_q;
				res.playing = 1'b1;
				cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					case (phase_q)
						PH_ON: begin
							phase_d = PH_OFF;
							key_d   = 1'b0;
							cnt_d   = u2;
						end
						PH_OFF: begin
							// rd_data_q holds the code after the finished element
							if (rd_data_q == CODE_LETTER_END) begin
								rp_d     = rp_q + AW'(2);
								phase_d  = PH_LETTER_GAP;
								key_d    = 1'b0;
								cnt_d    = u3;
								rd_req_d = 1'b1;
								rd_off_d = rp_q + AW'(2);
							end else if (rd_data_q inside {CODE_MSG_END}) begin
								rp_d     = rp_q + 1'b1;
								phase_d  = PH_LETTER_GAP;
								key_d    = 1'b0;
								cnt_d    = u3;
								rd_req_d = 1'b1;
								rd_off_d = rp_q + 1'b1;
							end else begin
								rp_d    = rp_q + 1'b1;
								do_elem = 1'b1;
								sl_code = rd_data_q;
							end
						end
						PH_LETTER_GAP: begin
							do_letter = 1'b1;
							sl_code   = rd_data_q;
						end
						PH_MSG_GAP: begin
							if (pend_q) begin
								do_load = 1'b1;
								sl_code = head_pend_q;
							end else begin
								rp_d      = '0;
								do_letter = 1'b1;
								sl_code   = head_act_q;
							end
						end
						default: begin
							phase_d = PH_IDLE;
							key_d   = 1'b0;
						end
					endcase
				end
			end
		end

		if (do_load) begin
			bank_d     = !bank_q;
			pend_d     = 1'b0;
			wp_d       = '0;
			elems_d    = '0;
			rp_d       = '0;
			head_act_d = sl_code;
			do_letter  = 1'b1;
		end

		// an empty letter ends the message
		if (do_letter) begin
			if (sl_code inside {CODE_LETTER_END, CODE_MSG_END}) begin
				phase_d = PH_MSG_GAP;
				key_d   = 1'b0;
				cnt_d   = u7;
			end else begin
				do_elem = 1'b1;
			end
		end

		if (do_elem) begin
			rd_req_d = 1'b1;
			rd_off_d = rp_d + 1'b1;
			case (sl_code)
				CODE_DOT: begin
					phase_d = PH_ON;
					key_d   = 1'b1;
					cnt_d   = u1;
				end
				CODE_DASH: begin
					phase_d = PH_ON;
					key_d   = 1'b1;
					cnt_d   = u3;
				end
				default: begin
					phase_d = PH_OFF;
					key_d   = 1'b0;
					cnt_d   = u5;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RESET;
			phase_q      <= PH_IDLE;
			key_q        <= 1'b0;
			cnt_q        <= '0;
			rp_q         <= '0;
			wp_q         <= '0;
			elems_q      <= '0;
			pend_q       <= 1'b0;
			ovf_q        <= 1'b0;
			bank_q       <= 1'b0;
			head_act_q   <= CODE_MSG_END;
			head_pend_q  <= CODE_MSG_END;
			rd_req_q     <= 1'b0;
			rd_addr_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				unit_ticks_q <= cfg_wdata;
			phase_q     <= phase_d;
			key_q       <= key_d;
			cnt_q       <= cnt_d;
			rp_q        <= rp_d;
			wp_q        <= wp_d;
			elems_q     <= elems_d;
			pend_q      <= pend_d;
			ovf_q       <= ovf_d;
			bank_q      <= bank_d;
			head_act_q  <= head_act_d;
			head_pend_q <= head_pend_d;
			// read goes out the cycle after the request, clear of any fresh write
			rd_req_q    <= rd_req_d;
			rd_addr_q   <= {bank_d, rd_off_d};
			if (fire && cmd.is_tick)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cmd.is_tick)
			out_item_q <= res;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[{!bank_q, wp_q}] <= wr_code;
		if (rd_req_q)
			rd_data_q <= mem[rd_addr_q];
	end

endmodule

### tb/sv/morse_keying_scoreboard.sv
`timescale 1ns / 1ps

module morse_keying_scoreboard (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [msp_pkg::UNIT_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  msp_pkg::in_item_t          in_item,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  msp_pkg::out_item_t         out_item,
	output int                         fail_count,
	output int                         due_count
);
	import msp_pkg::*;

	typedef enum logic [2:0] {
		SEG_IDLE,
		SEG_TONE,
		SEG_QUIET,
		SEG_LETTER_GAP,
		SEG_MSG_GAP
	} seg_t;

	code_t             live_msg [MSG_DEPTH_DEF];
	code_t             new_msg  [MSG_DEPTH_DEF];
	int                fill_ptr;
	int                play_ptr;
	int                elems_in_letter;
	seg_t              seg;
	logic [CNT_W-1:0]  seg_left;
	logic [UNIT_W-1:0] ticks_per_unit;
	logic              msg_waiting;
	logic              tone;
	logic              dropped_flag;
	out_item_t         keying_due [$];
	int                errors = 0;
	int                due_n = 0;

	assign fail_count = errors;
	assign due_count  = due_n;

	task automatic note_mismatch(input string what);
		$display("%0t: %s", $time, what);
		errors++;
	endtask

	function automatic void open_segment(input seg_t s, input logic key, input int units);
		logic [CNT_W-1:0] u;
		// a zero unit length behaves as one tick
		u = (ticks_per_unit == '0) ? CNT_W'(1) : CNT_W'(ticks_per_unit);
		seg      = s;
		tone     = key;
		seg_left = CNT_W'(units) * u;
	endfunction

	function automatic code_t live_code(input int idx);
		return (idx < MSG_DEPTH_DEF) ? live_msg[idx] : CODE_MSG_END;
	endfunction

	function automatic void open_element(input code_t c);
		case (c)
		CODE_DOT: begin
			open_segment(SEG_TONE, 1'b1, 1);
		end
		CODE_DASH: begin
			open_segment(SEG_TONE, 1'b1, 3);
		end
		default: begin
			open_segment(SEG_QUIET, 1'b0, 5);
		end
		endcase
	endfunction

	function automatic void open_letter();
		code_t c;
		c = live_code(play_ptr);
		// a letter with no elements closes the message
		if (c == CODE_LETTER_END || c == CODE_MSG_END)
			open_segment(SEG_MSG_GAP, 1'b0, 7);
		else
			open_element(c);
	endfunction

	function automatic void next_after_element();
		code_t c;
		play_ptr++;
		c = live_code(play_ptr);
		if (c == CODE_LETTER_END) begin
			play_ptr++;
			open_segment(SEG_LETTER_GAP, 1'b0, 3);
		end else if (c == CODE_MSG_END) begin
			open_segment(SEG_LETTER_GAP, 1'b0, 3);
		end else begin
			open_element(c);
		end
	endfunction

	function automatic void swap_in_message();
		live_msg        = new_msg;
		msg_waiting     = 1'b0;
		fill_ptr        = 0;
		elems_in_letter = 0;
		play_ptr        = 0;
		open_letter();
	endfunction

	function automatic void store_symbol(input logic [7:0] b);
		if (msg_waiting) begin
			dropped_flag = 1'b1;
		end else if (b == BYTE_NUL) begin
			new_msg[fill_ptr] = CODE_MSG_END;
			msg_waiting       = 1'b1;
			if (seg == SEG_IDLE)
				swap_in_message();
		end else if (fill_ptr + 1 >= MSG_DEPTH_DEF) begin
			// last slot stays free for the message end
			dropped_flag = 1'b1;
		end else if (b == BYTE_CR) begin
			new_msg[fill_ptr] = CODE_LETTER_END;
			fill_ptr++;
			elems_in_letter = 0;
		end else if (elems_in_letter >= MAX_ELEMS_DEF) begin
			dropped_flag = 1'b1;
		end else begin
			new_msg[fill_ptr] = (b == BYTE_DOT) ? CODE_DOT :
			                    (b == BYTE_DASH) ? CODE_DASH : CODE_SPACE;
			fill_ptr++;
			elems_in_letter++;
		end
	endfunction

	function automatic out_item_t clock_one_tick();
		out_item_t r;
		r.key_on  = 1'b0;
		r.playing = 1'b0;
		if (seg == SEG_IDLE) begin
			tone = 1'b0;
		end else begin
			r.key_on  = tone;
			r.playing = 1'b1;
			if (seg_left != '0)
				seg_left--;
			if (seg_left == '0) begin
				case (seg)
				SEG_TONE: begin
					open_segment(SEG_QUIET, 1'b0, 2);
				end
				SEG_QUIET: begin
					next_after_element();
				end
				SEG_LETTER_GAP: begin
					open_letter();
				end
				default: begin
					// closing gap over: take the waiting message or loop
					if (msg_waiting) begin
						swap_in_message();
					end else begin
						play_ptr = 0;
						open_letter();
					end
				end
				endcase
			end
		end
		r.overflow = dropped_flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			ticks_per_unit  = UNIT_TICKS_RESET;
			fill_ptr        = 0;
			play_ptr        = 0;
			elems_in_letter = 0;
			seg             = SEG_IDLE;
			seg_left        = '0;
			msg_waiting     = 1'b0;
			tone            = 1'b0;
			dropped_flag    = 1'b0;
			keying_due.delete();
			due_n           = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (keying_due.size() == 0) begin
					note_mismatch($sformatf("result beat %b with no tick waiting", out_item));
				end else begin
					want = keying_due.pop_front();
					if (out_item.key_on !== want.key_on)
						note_mismatch($sformatf("key_on %b, predicted %b",
							out_item.key_on, want.key_on));
					if (out_item.playing !== want.playing)
						note_mismatch($sformatf("playing %b, predicted %b",
							out_item.playing, want.playing));
					if (out_item.overflow !== want.overflow)
						note_mismatch($sformatf("overflow %b, predicted %b",
							out_item.overflow, want.overflow));
				end
			end
			if (in_valid && in_ready) begin
				if (in_item.req_type)
					store_symbol(in_item.symbol_byte);
				else
					keying_due.push_back(clock_one_tick());
			end
			if (cfg_we)
				ticks_per_unit = cfg_wdata;
			due_n = keying_due.size();
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import msp_pkg::*;

	localparam logic       REQ_TICK     = 1'b0;
	localparam logic       REQ_BYTE     = 1'b1;
	localparam logic [7:0] BYTE_SPACE   = 8'h20;
	localparam logic [7:0] BYTE_ODD     = 8'hFF;
	localparam int         QUIET_CYCLES = 12;
	localparam int         STALL_LIMIT  = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we = 1'b0;
	logic [UNIT_W-1:0] cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_item = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_item;
	int                fail_count;
	int                due_count;
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	int                beats_sent = 0;
	int                idle_run = 0;
	int                tick_scale = 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	morse_playback_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	morse_keying_scoreboard keying_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_beat(input logic kind, input logic [7:0] payload);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid            = 1'b1;
		in_item.req_type    = kind;
		in_item.symbol_byte = payload;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			push_beat(REQ_TICK, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b);
		push_beat(REQ_BYTE, b);
	endtask

	task automatic wait_for_results();
		in_valid = 1'b0;
		while (due_count != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// unit length only changes with nothing in flight
	task automatic start_phase(input logic [UNIT_W-1:0] unit, input int idle_pct,
		input int stall);
		wait_for_results();
		repeat (QUIET_CYCLES)
			@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = unit;
		@(negedge clk);
		cfg_we        = 1'b0;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		tick_scale    = (unit == '0 || unit > 16'd3) ? 1 : int'(unit);
	endtask

	function automatic logic [7:0] pick_element();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return BYTE_DOT;
		if (r < 90)
			return BYTE_DASH;
		if (r < 95)
			return BYTE_SPACE;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_message(input int letters, input int max_elems);
		repeat (letters) begin
			repeat ($urandom_range(1, max_elems))
				send_byte(pick_element());
			// a missing letter end merges two letters
			if ($urandom_range(7) != 0)
				send_byte(BYTE_CR);
		end
		send_byte(BYTE_NUL);
	endtask

	task automatic random_traffic(input int n);
		int stop_at;
		int r;
		stop_at = beats_sent + n;
		while (beats_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 55) begin
				send_message($urandom_range(1, 2), ($urandom_range(4) == 0) ? MAX_ELEMS_DEF : 4);
				send_ticks($urandom_range(10, 50) * tick_scale);
			end else if (r < 72) begin
				send_ticks($urandom_range(1, 20));
			end else if (r < 82) begin
				repeat ($urandom_range(1, 5))
					send_byte(8'($urandom_range(255)));
			end else if (r < 89) begin
				repeat ($urandom_range(MAX_ELEMS_DEF + 1, MAX_ELEMS_DEF + 4))
					send_byte(pick_element());
				send_byte(BYTE_CR);
				send_byte(BYTE_NUL);
			end else if (r < 95) begin
				// empty letter mid message: the tail is never played
				send_byte(BYTE_DOT);
				send_byte(BYTE_CR);
				send_byte(BYTE_CR);
				send_byte(BYTE_DASH);
				send_byte(BYTE_NUL);
			end else begin
				wait_for_results();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (8)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		start_phase(16'd1, 0, 0);
		send_ticks(1);
		send_byte(BYTE_NUL);
		send_ticks(1);
		send_byte(BYTE_DOT);
		send_byte(BYTE_DASH);
		send_byte(BYTE_SPACE);
		send_byte(BYTE_ODD);
		send_byte(BYTE_CR);
		send_byte(BYTE_CR);
		send_byte(BYTE_DOT);
		send_byte(BYTE_NUL);
		// lands while a finished message still waits
		send_byte(BYTE_DASH);
		send_ticks(6);
		repeat (MAX_ELEMS_DEF + 1)
			send_byte(BYTE_DASH);

		start_phase(16'd0, 0, 0);
		random_traffic(140);
		start_phase(16'd2, 83, 0);
		random_traffic(130);
		start_phase(16'd3, 0, 83);
		random_traffic(130);
		start_phase(16'd1, 25, 25);
		random_traffic(140);

		start_phase(16'hFFFF, 0, 0);
		random_traffic(30);

		wait_for_results();
		repeat (QUIET_CYCLES)
			@(negedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
